// ===== src/brba_pkg.sv =====
// shared types and constants for the boot region bump allocator
// no dependencies
`default_nettype none
package brba_pkg;
  localparam int MAX_REGIONS = 32;
  localparam int PAGE_SHIFT = 12;
  localparam int ADDR_BITS = 48;
  localparam int IDX_W = $clog2(MAX_REGIONS);
  localparam int CNT_W = $clog2(MAX_REGIONS + 1);

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_RESERVE = 2'd1;
  localparam logic [1:0] OP_ALLOC = 2'd2;
  localparam logic [1:0] OP_RETIRE = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_NOFIT = 2'd2;
  localparam logic [1:0] ST_RETIRED = 2'd3;

  localparam logic [7:0] USABLE_TYPE = 8'd1;

  localparam logic [63:0] AMASK64 = (64'hFFFF_FFFF_FFFF_FFFF) >> (64 - ADDR_BITS);
  localparam logic [47:0] AMASK = AMASK64[47:0];
  localparam logic [47:0] PMASK = (48'd1 << PAGE_SHIFT) - 48'd1;
  localparam logic [47:0] TOPPAGE = AMASK & ~PMASK;
  localparam logic [47:0] M48 = 48'hFFFF_FFFF_FFFF;

  typedef struct packed {
    logic [1:0]  op;
    logic [47:0] range_start;
    logic [47:0] range_end;
    logic [7:0]  region_type;
    logic [47:0] size;
    logic [40:0] align;
    logic [47:0] limit;
  } in_word_t;

  typedef struct packed {
    logic [47:0] alloc_addr;
    logic [1:0]  status;
    logic [5:0]  free_count;
    logic [47:0] highest_ram;
    logic [47:0] bytes_allocated;
  } out_word_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_ADD, S_CV_RD, S_CV_WR, S_CP_RD, S_CP_WR,
    S_AL_RD, S_AL_CHK, S_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic add_exec;
    logic cv_init;
    logic cv_wr;
    logic cp_init;
    logic cp_wr;
    logic al_init;
    logic al_chk;
    logic rd_ce;
    logic retire;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] op;
    logic       retired;
    logic       cv_last;
    logic       cp_last;
    logic       al_empty;
    logic       al_found;
    logic       al_last;
  } stat_t;

  function automatic logic [47:0] clamp_addr(input logic [48:0] a);
    clamp_addr = (a > {1'b0, AMASK}) ? AMASK : a[47:0];
  endfunction

  function automatic logic [47:0] up_page(input logic [47:0] a);
    up_page = (a > TOPPAGE) ? TOPPAGE : ((a + PMASK) & ~PMASK);
  endfunction
endpackage
`default_nettype wire

// ===== src/brba_ctrl.sv =====
// sequencing state machine of the boot region bump allocator
// depends on brba_pkg
`default_nettype none
module brba_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  output logic                busy,
  output brba_pkg::cmd_t      cmd,
  input  brba_pkg::stat_t     st
);
  import brba_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != S_IDLE);
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (st.op)
          OP_ADD: state_nxt = S_ADD;
          OP_RESERVE: begin
            cmd.cv_init = 1'b1;
            state_nxt = S_CV_RD;
          end
          OP_ALLOC: begin
            if (st.retired) state_nxt = S_DONE;
            else begin
              cmd.al_init = 1'b1;
              state_nxt = S_AL_RD;
            end
          end
          default: begin
            cmd.retire = 1'b1;
            state_nxt = S_DONE;
          end
        endcase
      end
      S_ADD: begin
        cmd.add_exec = 1'b1;
        state_nxt = S_DONE;
      end
      S_CV_RD: begin
        cmd.rd_ce = 1'b1;
        state_nxt = st.cv_last ? S_CP_RD : S_CV_WR;
        if (st.cv_last) cmd.cp_init = 1'b1;
      end
      S_CV_WR: begin
        cmd.cv_wr = 1'b1;
        state_nxt = S_CV_RD;
      end
      S_CP_RD: begin
        cmd.rd_ce = 1'b1;
        state_nxt = st.cp_last ? S_DONE : S_CP_WR;
      end
      S_CP_WR: begin
        cmd.cp_wr = 1'b1;
        state_nxt = S_CP_RD;
      end
      S_AL_RD: begin
        cmd.rd_ce = 1'b1;
        state_nxt = st.al_empty ? S_DONE : S_AL_CHK;
      end
      S_AL_CHK: begin
        cmd.al_chk = 1'b1;
        priority if (st.al_found) begin
          cmd.cv_init = 1'b1;
          state_nxt = S_CV_RD;
        end else if (st.al_last) state_nxt = S_DONE;
        else state_nxt = S_AL_RD;
      end
      S_DONE: begin
        cmd.finish = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

// ===== src/brba_dp.sv =====
// datapath of the boot region bump allocator: region table, carve and search
// depends on brba_pkg
`default_nettype none
module brba_dp (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  brba_pkg::in_word_t     in_word,
  input  brba_pkg::cmd_t         cmd,
  output brba_pkg::stat_t        st,
  output logic                   out_valid,
  output brba_pkg::out_word_t    out_word
);
  import brba_pkg::*;

  logic [95:0] mem_r [MAX_REGIONS];
  logic [95:0] rd_r;

  in_word_t   req_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [47:0] top_r, top_nxt;
  logic        ret_r, ret_nxt;
  logic [47:0] tot_r, tot_nxt;
  logic [CNT_W-1:0] i_r, i_nxt;
  logic [CNT_W-1:0] j_r, j_nxt;
  logic [CNT_W-1:0] lim_r, lim_nxt;
  logic [47:0] rb_r, rb_nxt, re_r, re_nxt;
  logic [47:0] psz_r, psz_nxt, lm_r, lm_nxt, amask_r, amask_nxt;
  logic [47:0] addr_r, addr_nxt;
  logic [1:0]  status_r, status_nxt;
  logic        isalloc_r, isalloc_nxt;
  logic        ov_r, ov_nxt;
  logic        rng_pend_r, rng_pend_nxt;
  logic        valid_r;
  out_word_t   out_r;

  logic        we;
  logic [IDX_W-1:0] wa, ra;
  logic [95:0] wd;

  logic [47:0] ob, oe, le, nb, al_e, al_b, ae, as, ab;
  logic        hit, ovl;
  logic [47:0] al_m;

  assign ob = rd_r[95:48];
  assign oe = rd_r[47:0];
  assign ovl = !(re_r <= ob || rb_r >= oe);
  assign le = (rb_r < oe) ? rb_r : oe;
  assign nb = (re_r > ob) ? re_r : ob;
  assign al_e = (oe < lm_r) ? oe : lm_r;
  assign al_b = (al_e - psz_r) & amask_r;
  assign hit = !(al_e < psz_r) && !(al_b < ob);
  assign al_m = {7'd0, req_r.align} - 48'd1;
  assign as = clamp_addr({1'b0, req_r.range_start});
  assign ae = clamp_addr({1'b0, req_r.range_start} + {1'b0, req_r.size}) & ~PMASK;
  assign ab = (as + PMASK) & ~PMASK;

  always_comb begin
    st.op = req_r.op;
    st.retired = ret_r;
    st.cv_last = (i_r >= lim_r);
    st.cp_last = (i_r >= cnt_r);
    st.al_empty = (i_r == '0);
    st.al_found = hit;
    st.al_last = (i_r == '0);
  end

  always_comb begin
    ra = i_r[IDX_W-1:0];
    if (st.al_empty == 1'b0 && isalloc_r && !ov_r) ra = IDX_W'(i_r - 1'b1);
  end

  always_comb begin
    cnt_nxt = cnt_r; top_nxt = top_r; ret_nxt = ret_r; tot_nxt = tot_r;
    i_nxt = i_r; j_nxt = j_r; lim_nxt = lim_r; rb_nxt = rb_r; re_nxt = re_r;
    psz_nxt = psz_r; lm_nxt = lm_r; amask_nxt = amask_r; addr_nxt = addr_r;
    status_nxt = status_r; isalloc_nxt = isalloc_r; ov_nxt = ov_r;
    rng_pend_nxt = rng_pend_r;
    we = 1'b0; wa = i_r[IDX_W-1:0]; wd = rd_r;
    if (cmd.load) begin
      addr_nxt = '0; status_nxt = ST_OK; isalloc_nxt = 1'b0; ov_nxt = 1'b0;
      rng_pend_nxt = 1'b0;
    end
    if (cmd.add_exec && req_r.region_type == USABLE_TYPE) begin
      if (as <= TOPPAGE && ae > ab) begin
        if (cnt_r >= CNT_W'(MAX_REGIONS)) status_nxt = ST_FULL;
        else begin
          we = 1'b1; wa = cnt_r[IDX_W-1:0]; wd = {ab, ae};
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      if (ae > top_r) top_nxt = ae;
    end
    if (cmd.retire) ret_nxt = 1'b1;
    if (cmd.al_init) begin
      amask_nxt = (req_r.align == '0) ? M48 : ~al_m;
      lm_nxt = clamp_addr({1'b0, req_r.limit});
      psz_nxt = (req_r.size + PMASK) & ~PMASK;
      i_nxt = cnt_r;
      isalloc_nxt = 1'b1;
      status_nxt = ST_NOFIT;
      if (req_r.size > TOPPAGE) i_nxt = '0;
    end
    if (cmd.al_chk) begin
      if (hit) begin
        addr_nxt = al_b;
        status_nxt = ST_OK;
        tot_nxt = (M48 - tot_r < psz_r) ? M48 : tot_r + psz_r;
        rng_pend_nxt = 1'b1;
      end else i_nxt = i_r - 1'b1;
    end
    if (cmd.cv_init) begin
      i_nxt = '0;
      lim_nxt = cnt_r;
      ov_nxt = 1'b1;
      if (!isalloc_r) begin
        rb_nxt = clamp_addr({1'b0, req_r.range_start}) & ~PMASK;
        re_nxt = up_page(clamp_addr({1'b0, req_r.range_end}));
      end
    end
    // carve bounds of the allocated block, formed in the first carve read cycle
    if (rng_pend_r) begin
      rb_nxt = addr_r & ~PMASK;
      re_nxt = up_page(clamp_addr({1'b0, addr_r} + {1'b0, psz_r}));
      rng_pend_nxt = 1'b0;
    end
    if (cmd.cv_wr) begin
      i_nxt = i_r + 1'b1;
      if (ovl) begin
        we = 1'b1; wa = i_r[IDX_W-1:0];
        wd = {ob, (le > ob) ? le : ob};
        if (re_r < oe) begin
          if (cnt_nxt >= CNT_W'(MAX_REGIONS)) status_nxt = ST_FULL;
          else cnt_nxt = cnt_r + 1'b1;
        end
      end
    end
    if (cmd.cp_init) begin
      i_nxt = '0; j_nxt = '0;
    end
    if (cmd.cp_wr) begin
      i_nxt = i_r + 1'b1;
      if (oe > ob) begin
        we = 1'b1; wa = j_r[IDX_W-1:0]; wd = rd_r;
        j_nxt = j_r + 1'b1;
      end
    end
    if (cmd.finish && ov_r) cnt_nxt = j_r;
  end

  // second write port for split right parts, written in the same cycle as the left part
  logic        we2;
  logic [IDX_W-1:0] wa2;
  logic [95:0] wd2;
  always_comb begin
    we2 = cmd.cv_wr && ovl && (re_r < oe) && (cnt_r < CNT_W'(MAX_REGIONS));
    wa2 = cnt_r[IDX_W-1:0];
    wd2 = {nb, oe};
  end

  always_ff @(posedge clk) begin
    if (we) mem_r[wa] <= wd;
    if (we2) mem_r[wa2] <= wd2;
    if (cmd.rd_ce) rd_r <= mem_r[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; top_r <= '0; ret_r <= 1'b0; tot_r <= '0; valid_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt; top_r <= top_nxt; ret_r <= ret_nxt; tot_r <= tot_nxt;
      valid_r <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) req_r <= in_word;
    i_r <= i_nxt; j_r <= j_nxt; lim_r <= lim_nxt; rb_r <= rb_nxt; re_r <= re_nxt;
    psz_r <= psz_nxt; lm_r <= lm_nxt; amask_r <= amask_nxt; addr_r <= addr_nxt;
    status_r <= status_nxt; isalloc_r <= isalloc_nxt; ov_r <= ov_nxt;
    rng_pend_r <= rng_pend_nxt;
    if (cmd.finish) begin
      out_r.alloc_addr <= addr_nxt;
      out_r.status <= (req_r.op == OP_ALLOC && ret_r) ? ST_RETIRED : status_nxt;
      out_r.free_count <= 6'(cnt_nxt);
      out_r.highest_ram <= top_nxt;
      out_r.bytes_allocated <= tot_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word = out_r;
endmodule
`default_nettype wire

// ===== src/boot_region_bump_allocator_core.sv =====
// top level of the boot region bump allocator
// depends on brba_pkg, brba_ctrl, brba_dp
// usage:
//   a command word is taken when start is high and busy is low
//   busy stays high until the result word has been formed
//   the result word appears on out_word for one cycle with out_valid high
//   the receiver cannot stall; each command yields exactly one result
// sequencing:
//   add runs through decode, add and done; retire and a refused alloc go from decode to done
//   reserve walks the table twice, a read and a write state per entry for the carve
//   and a read and a write state per entry for the compaction
//   alloc searches top-down over the n entries (n at most 32), a read and a check
//   state per entry tried, then carves and compacts as reserve does
//   the table has a single read port, so entries are read one at a time
// reset:
//   rst_n low empties the table, clears the highest ram mark, the
//   allocated total and the retired flag; table contents are not cleared
`default_nettype none
module boot_region_bump_allocator_core (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  brba_pkg::in_word_t    in_word,
  output logic                  out_valid,
  output brba_pkg::out_word_t   out_word
);
  import brba_pkg::*;

  cmd_t  cmd;
  stat_t st;

  brba_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd), .st(st)
  );

  brba_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_word(in_word), .cmd(cmd), .st(st),
    .out_valid(out_valid), .out_word(out_word)
  );
endmodule
`default_nettype wire
